FILE: rtl/core/tlbrp_pkg.sv
package tlbrp_pkg;

  // Table geometry and field widths
  localparam int ENTRIES   = 16;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int PAGE_W    = 20;
  localparam int OUT_IDX_W = 4;
  localparam int CLOCK_W   = 32;
  localparam int COUNT_W   = 16;
  localparam int POLICY_W  = 2;

  // Replacement policy codes (code 3 falls back to oldest insert)
  localparam logic [POLICY_W-1:0] POL_FIFO = 2'd0;
  localparam logic [POLICY_W-1:0] POL_LRU  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_LFU  = 2'd2;

  // Command codes
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  typedef struct packed {
    logic              command;
    logic [PAGE_W-1:0] page_number;
    logic [PAGE_W-1:0] frame_number;
  } req_t;

  typedef struct packed {
    logic                 hit;
    logic [PAGE_W-1:0]    found_frame;
    logic [OUT_IDX_W-1:0] entry_index;
  } rsp_t;

  // One entry as seen on the store's read port
  typedef struct packed {
    logic               valid;
    logic [PAGE_W-1:0]  page;
    logic [PAGE_W-1:0]  frame;
    logic [CLOCK_W-1:0] added;
    logic [CLOCK_W-1:0] last_used;
    logic [COUNT_W-1:0] use_count;
  } entry_t;

  // Update to the store: fill a slot, or touch it after a hit
  typedef struct packed {
    logic               en;
    logic               fill;
    logic [IDX_W-1:0]   idx;
    logic [PAGE_W-1:0]  page;
    logic [PAGE_W-1:0]  frame;
    logic [CLOCK_W-1:0] stamp;
  } wr_t;

  // Completion of one request from the sequencer
  typedef struct packed {
    logic done;
    rsp_t rsp;
  } fin_t;

endpackage

FILE: rtl/core/tlbrp_store.sv
module tlbrp_store (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [tlbrp_pkg::IDX_W-1:0]      rd_idx,
  output tlbrp_pkg::entry_t                rd,
  input  tlbrp_pkg::wr_t                   wr
);

  logic                            valid     [tlbrp_pkg::ENTRIES];
  logic [tlbrp_pkg::PAGE_W-1:0]    page      [tlbrp_pkg::ENTRIES];
  logic [tlbrp_pkg::PAGE_W-1:0]    frame     [tlbrp_pkg::ENTRIES];
  logic [tlbrp_pkg::CLOCK_W-1:0]   added     [tlbrp_pkg::ENTRIES];
  logic [tlbrp_pkg::CLOCK_W-1:0]   last_used [tlbrp_pkg::ENTRIES];
  logic [tlbrp_pkg::COUNT_W-1:0]   use_count [tlbrp_pkg::ENTRIES];
  logic [tlbrp_pkg::COUNT_W-1:0]   count_next;

  // Select the entry under the scan pointer
  always_comb begin
    rd.valid     = valid[rd_idx];
    rd.page      = page[rd_idx];
    rd.frame     = frame[rd_idx];
    rd.added     = added[rd_idx];
    rd.last_used = last_used[rd_idx];
    rd.use_count = use_count[rd_idx];
  end

  // Saturating use count for the entry being touched
  always_comb begin
    if (use_count[wr.idx] == {tlbrp_pkg::COUNT_W{1'b1}}) begin
      count_next = use_count[wr.idx];
    end else begin
      count_next = use_count[wr.idx] + tlbrp_pkg::COUNT_W'(1);
    end
  end

  // Clear valid bits on reset, set them on fill
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tlbrp_pkg::ENTRIES; i++) begin
        valid[i] <= 1'b0;
      end
    end else if (wr.en && wr.fill) begin
      valid[wr.idx] <= 1'b1;
    end
  end

  // Write entry payload
  always_ff @(posedge clk) begin
    if (wr.en) begin
      last_used[wr.idx] <= wr.stamp;
      if (wr.fill) begin
        page[wr.idx]      <= wr.page;
        frame[wr.idx]     <= wr.frame;
        added[wr.idx]     <= wr.stamp;
        use_count[wr.idx] <= '0;
      end else begin
        use_count[wr.idx] <= count_next;
      end
    end
  end

endmodule

FILE: rtl/core/tlbrp_seq.sv
module tlbrp_seq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  tlbrp_pkg::req_t                 req,
  input  logic [tlbrp_pkg::POLICY_W-1:0]  policy,
  input  logic [tlbrp_pkg::CLOCK_W-1:0]   stamp,
  output logic [tlbrp_pkg::IDX_W-1:0]     rd_idx,
  input  tlbrp_pkg::entry_t               rd,
  output tlbrp_pkg::wr_t                  wr,
  output tlbrp_pkg::fin_t                 fin
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_WRITE = 3'b100
  } state_t;

  state_t                          state;
  tlbrp_pkg::req_t                 cur;
  logic [tlbrp_pkg::IDX_W-1:0]     idx;
  logic [tlbrp_pkg::IDX_W-1:0]     sel_idx;
  logic [tlbrp_pkg::IDX_W-1:0]     best_idx;
  logic [tlbrp_pkg::CLOCK_W-1:0]   best_key;
  logic                            found;
  logic [tlbrp_pkg::PAGE_W-1:0]    frame;

  logic [tlbrp_pkg::CLOCK_W-1:0]   key;
  logic                            take;
  logic [tlbrp_pkg::IDX_W-1:0]     best_idx_next;
  logic [tlbrp_pkg::CLOCK_W-1:0]   best_key_next;
  logic                            last;
  logic                            match;

  assign busy   = (state != ST_IDLE);
  assign rd_idx = idx;
  assign last   = (idx == tlbrp_pkg::IDX_W'(tlbrp_pkg::ENTRIES - 1));
  assign match  = rd.valid && (rd.page == cur.page_number);

  // Victim key of the entry under the pointer
  always_comb begin
    case (policy)
      tlbrp_pkg::POL_LRU: key = rd.last_used;
      tlbrp_pkg::POL_LFU: key = tlbrp_pkg::CLOCK_W'(rd.use_count);
      default:            key = rd.added;
    endcase
  end

  // Shared compare: keep the strictly smaller key, first entry seeds it
  always_comb begin
    take = (idx == '0) || (key < best_key);
    if (take) begin
      best_idx_next = idx;
      best_key_next = key;
    end else begin
      best_idx_next = best_idx;
      best_key_next = best_key;
    end
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cur.command == tlbrp_pkg::CMD_LOOKUP) begin
            if (match || last) begin
              state <= ST_WRITE;
            end
          end else if (!rd.valid || last) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
    end
  end

  // Hold request and scan results
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur   <= req;
        idx   <= '0;
        found <= 1'b0;
      end
      ST_SCAN: begin
        idx <= idx + tlbrp_pkg::IDX_W'(1);
        if (cur.command == tlbrp_pkg::CMD_LOOKUP) begin
          if (match) begin
            found   <= 1'b1;
            sel_idx <= idx;
            frame   <= rd.frame;
          end
        end else if (!rd.valid) begin
          sel_idx <= idx;
        end else begin
          best_idx <= best_idx_next;
          best_key <= best_key_next;
          sel_idx  <= best_idx_next;
        end
      end
      default: begin
      end
    endcase
  end

  // Drive the store update and the completion
  always_comb begin
    wr.en    = (state == ST_WRITE) && ((cur.command == tlbrp_pkg::CMD_INSERT) || found);
    wr.fill  = (cur.command == tlbrp_pkg::CMD_INSERT);
    wr.idx   = sel_idx;
    wr.page  = cur.page_number;
    wr.frame = cur.frame_number;
    wr.stamp = stamp;

    fin.done            = (state == ST_WRITE);
    fin.rsp.hit         = found;
    fin.rsp.found_frame = found ? frame : '0;
    if ((cur.command == tlbrp_pkg::CMD_INSERT) || found) begin
      fin.rsp.entry_index = tlbrp_pkg::OUT_IDX_W'(sel_idx);
    end else begin
      fin.rsp.entry_index = '0;
    end
  end

endmodule

FILE: rtl/core/tlb_with_replacement_policy.sv
// Channel   | Signals                 | Handshake
// ----------+-------------------------+------------------------------------------
// request   | start, busy, req        | taken at a clock edge with start & !busy
// result    | done, rsp               | done high one cycle, always taken
// config    | wr_en, wr_data          | replacement policy written when wr_en high
//
// A request scans the entries one per cycle through one compare unit, then
// ends with the update state; a lookup stops its scan at the first hit.
// The result shows in the cycle after the update. Reset empties every
// entry, sets the policy to oldest insert and clears the request counter.
// The receiver cannot stall.
module tlb_with_replacement_policy (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  tlbrp_pkg::req_t                  req,
  output logic                             done,
  output tlbrp_pkg::rsp_t                  rsp,
  input  logic                             wr_en,
  input  logic [tlbrp_pkg::POLICY_W-1:0]   wr_data
);

  logic [tlbrp_pkg::POLICY_W-1:0]  policy;
  logic [tlbrp_pkg::CLOCK_W-1:0]   item_clock;
  logic [tlbrp_pkg::IDX_W-1:0]     rd_idx;
  tlbrp_pkg::entry_t               rd;
  tlbrp_pkg::wr_t                  wr;
  tlbrp_pkg::fin_t                 fin;

  tlbrp_store u_store (
    .clk    (clk),
    .rst    (rst),
    .rd_idx (rd_idx),
    .rd     (rd),
    .wr     (wr)
  );

  tlbrp_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .policy (policy),
    .stamp  (item_clock),
    .rd_idx (rd_idx),
    .rd     (rd),
    .wr     (wr),
    .fin    (fin)
  );

  // Hold the policy register
  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= tlbrp_pkg::POL_FIFO;
    end else if (wr_en) begin
      policy <= wr_data;
    end
  end

  // Advance the saturating request counter
  always_ff @(posedge clk) begin
    if (rst) begin
      item_clock <= '0;
    end else if (fin.done && (item_clock != {tlbrp_pkg::CLOCK_W{1'b1}})) begin
      item_clock <= item_clock + tlbrp_pkg::CLOCK_W'(1);
    end
  end

  // Register the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin.done;
    end
  end

  // Register the result payload
  always_ff @(posedge clk) begin
    if (fin.done) begin
      rsp <= fin.rsp;
    end
  end

endmodule

FILE: dv/tb_tlb_with_replacement_policy.sv
`timescale 1ns / 1ps

module tb_tlb_with_replacement_policy;
  import tlbrp_pkg::*;

  // Policy code 3 has no name in the package; it falls back to oldest insert
  localparam logic [POLICY_W-1:0] POL_RESERVED = 2'd3;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOT_LOOKUPS = 40;
  localparam int POOL_SIZE   = 24;
  localparam int PHASE_REQS  = 180;

  logic                clk     = 1'b0;
  logic                rst     = 1'b1;
  logic                start   = 1'b0;
  logic                busy;
  req_t                req     = '0;
  logic                done;
  rsp_t                rsp;
  logic                wr_en   = 1'b0;
  logic [POLICY_W-1:0] wr_data = '0;

  tlb_with_replacement_policy dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req     (req),
    .done    (done),
    .rsp     (rsp),
    .wr_en   (wr_en),
    .wr_data (wr_data)
  );

  always #10 clk = ~clk;

  // Shadow copy of the translation table
  logic                ent_valid   [ENTRIES];
  logic [PAGE_W-1:0]   ent_page    [ENTRIES];
  logic [PAGE_W-1:0]   ent_frame   [ENTRIES];
  logic [CLOCK_W-1:0]  ent_added   [ENTRIES];
  logic [CLOCK_W-1:0]  ent_touched [ENTRIES];
  logic [COUNT_W-1:0]  ent_uses    [ENTRIES];
  logic [CLOCK_W-1:0]  req_clock;
  logic [POLICY_W-1:0] cur_policy;

  rsp_t translation_q[$];
  int   mismatch_count = 0;
  int   idle_cycles    = 0;

  // Apply one request to the shadow table and return the translation it yields
  function automatic rsp_t translate_request(input req_t r);
    rsp_t               o;
    logic [CLOCK_W-1:0] key;
    logic [CLOCK_W-1:0] best_key;
    int                 slot;
    bit                 found;
    o        = '0;
    found    = 1'b0;
    slot     = -1;
    best_key = '0;
    if (r.command == CMD_LOOKUP) begin
      // lowest-indexed valid match wins
      for (int i = 0; i < ENTRIES; i++) begin
        if (!found && ent_valid[i] && ent_page[i] == r.page_number) begin
          found          = 1'b1;
          ent_touched[i] = req_clock;
          if (ent_uses[i] != '1) ent_uses[i] = ent_uses[i] + 1'b1;
          o.hit          = 1'b1;
          o.found_frame  = ent_frame[i];
          o.entry_index  = OUT_IDX_W'(i);
        end
      end
    end else begin
      // first free slot, else the victim with the strictly smallest key
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot < 0 && !ent_valid[i]) slot = i;
      end
      if (slot < 0) begin
        for (int i = 0; i < ENTRIES; i++) begin
          case (cur_policy)
            POL_LRU: key = ent_touched[i];
            POL_LFU: key = CLOCK_W'(ent_uses[i]);
            default: key = ent_added[i];
          endcase
          if (i == 0 || key < best_key) begin
            best_key = key;
            slot     = i;
          end
        end
      end
      ent_valid[slot]   = 1'b1;
      ent_page[slot]    = r.page_number;
      ent_frame[slot]   = r.frame_number;
      ent_added[slot]   = req_clock;
      ent_touched[slot] = req_clock;
      ent_uses[slot]    = '0;
      o.entry_index     = OUT_IDX_W'(slot);
    end
    if (req_clock != '1) req_clock = req_clock + 1'b1;
    return o;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // Drive one request after a gap and hold it until the block takes it
  task automatic send_request(input logic cmd, input logic [PAGE_W-1:0] page,
                              input logic [PAGE_W-1:0] frame, input int gap);
    req_t r;
    bit   taken;
    r.command      = cmd;
    r.page_number  = page;
    r.frame_number = frame;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = (busy === 1'b0);
      @(posedge clk);
    end
    translation_q.push_back(translate_request(r));
  endtask

  // Drop start and wait until every translation has come back
  task automatic wait_idle(input int settle);
    start <= 1'b0;
    while (translation_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_policy(input logic [POLICY_W-1:0] p);
    wait_idle(4);
    wr_en   <= 1'b1;
    wr_data <= p;
    @(posedge clk);
    wr_en      <= 1'b0;
    cur_policy = p;
  endtask

  // Compare each result with the oldest outstanding translation
  always @(negedge clk) begin
    rsp_t want;
    if (!rst && done === 1'b1) begin
      if (translation_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result hit=%0b frame=%05h index=%0d",
                                  rsp.hit, rsp.found_frame, rsp.entry_index));
      end else begin
        want = translation_q.pop_front();
        if (rsp.hit !== want.hit)
          report_mismatch($sformatf("hit %0b, expected %0b", rsp.hit, want.hit));
        if (rsp.found_frame !== want.found_frame)
          report_mismatch($sformatf("found_frame %05h, expected %05h",
                                    rsp.found_frame, want.found_frame));
        if (rsp.entry_index !== want.entry_index)
          report_mismatch($sformatf("entry_index %0d, expected %0d",
                                    rsp.entry_index, want.entry_index));
      end
    end
  end

  // End the run when nothing moves for too long
  always @(negedge clk) begin
    if (rst || (start && busy === 1'b0) || done === 1'b1) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Lookups on an empty table miss, extreme pages included
  task automatic test_empty_lookup();
    send_request(CMD_LOOKUP, '0, '1, 0);
    send_request(CMD_LOOKUP, '1, '0, $urandom_range(0, 7));
  endtask

  // Hammer entry 0 with many hits, then let LFU spare the hot entry
  task automatic test_hot_entry_lfu();
    logic [PAGE_W-1:0] hot;
    hot = PAGE_W'($urandom);
    send_request(CMD_INSERT, hot, PAGE_W'($urandom), 0);
    for (int n = 0; n < HOT_LOOKUPS; n++)
      send_request(CMD_LOOKUP, hot, PAGE_W'($urandom), (n % 8 == 0) ? $urandom_range(0, 7) : 0);
    for (int k = 1; k < ENTRIES; k++)
      send_request(CMD_INSERT, hot ^ PAGE_W'(k), PAGE_W'($urandom), $urandom_range(0, 7));
    for (int k = 1; k < ENTRIES; k++) begin
      send_request(CMD_LOOKUP, hot ^ PAGE_W'(k), '0, $urandom_range(0, 7));
      send_request(CMD_LOOKUP, hot ^ PAGE_W'(k), '1, 0);
    end
    set_policy(POL_LFU);
    send_request(CMD_INSERT, ~hot, PAGE_W'($urandom), 0);
    send_request(CMD_LOOKUP, ~hot, '0, 0);
    send_request(CMD_LOOKUP, hot, '0, 0);
  endtask

  // Extreme pages and frames, and a duplicate insert of the same page
  task automatic test_extreme_fields();
    set_policy(POL_FIFO);
    send_request(CMD_INSERT, '0, '1, 0);
    send_request(CMD_INSERT, '1, '0, $urandom_range(0, 7));
    send_request(CMD_LOOKUP, '0, '0, 0);
    send_request(CMD_LOOKUP, '1, '1, $urandom_range(0, 7));
    send_request(CMD_INSERT, '0, PAGE_W'($urandom), 0);
    send_request(CMD_LOOKUP, '0, '0, 0);
  endtask

  // Force replacements under each remaining policy code
  task automatic test_policy_victims();
    logic [POLICY_W-1:0] order [3];
    logic [PAGE_W-1:0]   fresh;
    order = '{POL_LRU, POL_LFU, POL_RESERVED};
    foreach (order[p]) begin
      set_policy(order[p]);
      send_request(CMD_LOOKUP, '1, '0, 0);
      fresh = PAGE_W'($urandom);
      send_request(CMD_INSERT, fresh, PAGE_W'($urandom), $urandom_range(0, 7));
      send_request(CMD_INSERT, PAGE_W'($urandom), PAGE_W'($urandom), 0);
      send_request(CMD_LOOKUP, fresh, '0, $urandom_range(0, 7));
    end
  endtask

  // Mixed traffic over a small page pool so that hits and evictions are common
  task automatic test_random_traffic();
    logic [POLICY_W-1:0] plan [6];
    logic [PAGE_W-1:0]   pool [POOL_SIZE];
    logic [PAGE_W-1:0]   page;
    logic                cmd;
    bit                  calm;
    int                  gap;
    plan    = '{POL_FIFO, POL_LRU, POL_LFU, POL_RESERVED, POL_FIFO, POL_FIFO};
    plan[4] = POLICY_W'($urandom_range(0, 3));
    plan[5] = POLICY_W'($urandom_range(0, 3));
    calm    = 1'b0;
    foreach (plan[ph]) begin
      set_policy(plan[ph]);
      foreach (pool[i]) pool[i] = PAGE_W'($urandom);
      pool[0] = '0;
      pool[1] = '1;
      for (int n = 0; n < PHASE_REQS; n++) begin
        if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        gap = calm ? 0 : $urandom_range(0, 7);
        cmd = ($urandom_range(0, 99) < 55) ? CMD_LOOKUP : CMD_INSERT;
        if ($urandom_range(0, 9) == 0)
          page = PAGE_W'($urandom);
        else if ($urandom_range(0, 1) == 1)
          page = pool[$urandom_range(0, 5)];
        else
          page = pool[$urandom_range(0, POOL_SIZE - 1)];
        send_request(cmd, page, PAGE_W'($urandom), gap);
      end
    end
  endtask

  initial begin
    // clear the shadow table to its reset state
    for (int i = 0; i < ENTRIES; i++) begin
      ent_valid[i]   = 1'b0;
      ent_page[i]    = '0;
      ent_frame[i]   = '0;
      ent_added[i]   = '0;
      ent_touched[i] = '0;
      ent_uses[i]    = '0;
    end
    req_clock  = '0;
    cur_policy = POL_FIFO;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_empty_lookup();
    test_hot_entry_lfu();
    test_extreme_fields();
    test_policy_victims();
    test_random_traffic();

    wait_idle(ENTRIES + 4);
    if (mismatch_count == 0 && translation_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
